>>> rtl/multi_waveform_generator_defines.svh
// Assertion macros for the waveform generator.
// MWG_ASSERT_CLK names its clock and active-low reset; MWG_ASSERT uses aclk and aresetn.
`ifndef MULTI_WAVEFORM_GENERATOR_DEFINES_SVH
`define MULTI_WAVEFORM_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define MWG_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MWG_ASSERT(lbl, prop, msg) \
    `MWG_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)
`else
`define MWG_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define MWG_ASSERT(lbl, prop, msg)
`endif

`endif

>>> rtl/mwg_pkg.sv
package mwg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int FRAC_BITS  = SAMPLE_BITS - 1;
    localparam int AMP_W      = SAMPLE_BITS - 1;
    localparam int UNIT_W     = FRAC_BITS + 3;
    localparam int QBITS      = SINE_TABLE_BITS - 2;
    localparam int QUARTER    = 1 << QBITS;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WAVE_MODE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_OFFSET = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE    = 2'd3;

    // waveform codes
    localparam logic [1:0] MODE_SINE     = 2'd0;
    localparam logic [1:0] MODE_SQUARE   = 2'd1;
    localparam logic [1:0] MODE_TRIANGLE = 2'd2;
    localparam logic [1:0] MODE_SAWTOOTH = 2'd3;

    localparam logic signed [UNIT_W-1:0] UNIT_ONE   = UNIT_W'(1 << FRAC_BITS);
    localparam logic signed [UNIT_W-1:0] UNIT_THREE = UNIT_W'(3 << FRAC_BITS);
    localparam logic [PHASE_BITS-1:0]    PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};

    // sin(pi/2*u) odd polynomial coefficients, Q30
    localparam logic [63:0] C1  = 64'd1686629713;
    localparam logic [63:0] C3  = 64'd693598668;
    localparam logic [63:0] C5  = 64'd85569306;
    localparam logic [63:0] C7  = 64'd5026995;
    localparam logic [63:0] C9  = 64'd172272;
    localparam logic [63:0] C11 = 64'd3864;

    typedef logic [FRAC_BITS:0] sine_mag_t;
    typedef sine_mag_t sine_lut_t [QUARTER];

    // Quarter-wave magnitude for step k of QUARTER, rounded to Q1.F and clamped to 1.0
    function automatic sine_mag_t sine_value(input int unsigned k);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] v;
        u  = 64'(k) << (30 - QBITS);
        u2 = (u * u) >> 30;
        r  = C11;
        r  = C9 - ((r * u2) >> 30);
        r  = C7 - ((r * u2) >> 30);
        r  = C5 - ((r * u2) >> 30);
        r  = C3 - ((r * u2) >> 30);
        r  = C1 - ((r * u2) >> 30);
        s  = (r * u) >> 30;
        v  = (s + (64'd1 << (30 - FRAC_BITS - 1))) >> (30 - FRAC_BITS);
        if (v > (64'd1 << FRAC_BITS)) begin
            v = 64'd1 << FRAC_BITS;
        end
        return v[FRAC_BITS:0];
    endfunction

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t lut;
        for (int i = 0; i < QUARTER; i++) begin
            lut[i] = sine_value(i);
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT  = build_sine_lut();
    localparam sine_mag_t SINE_PEAK = sine_value(QUARTER);

endpackage

>>> rtl/multi_waveform_generator.sv
// Input transactions reach m_tvalid/m_tdata via the stage one and stage two registers.
// One sample per clock unless m_tready stalls; the phase accumulator add is the only loop.
// Stage one forms the unit wave from the phase, stage two scales and rounds it.
// Reset (aresetn low at a rising edge) clears the phase, all config registers
// and both pipeline valids.
`include "multi_waveform_generator_defines.svh"

module multi_waveform_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mwg_pkg::S_TDATA_W-1:0]       s_tdata,     // [0] restart, [7:1] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mwg_pkg::M_TDATA_W-1:0]       m_tdata,     // [15:0] sample
    input  logic                                cfg_wr_en,
    input  logic [mwg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mwg_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int PB = mwg_pkg::PHASE_BITS;
    localparam int TB = mwg_pkg::SINE_TABLE_BITS;
    localparam int QB = mwg_pkg::QBITS;
    localparam int F  = mwg_pkg::FRAC_BITS;
    localparam int UW = mwg_pkg::UNIT_W;
    localparam int AW = mwg_pkg::AMP_W;
    localparam int SB = mwg_pkg::SAMPLE_BITS;
    localparam int PW = AW + F + 1;

    // configuration
    logic [1:0]    wave_mode_reg;
    logic [PB-1:0] phase_step_reg;
    logic [PB-1:0] phase_offset_reg;
    logic [AW-1:0] amplitude_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_mode_reg    <= mwg_pkg::MODE_SINE;
            phase_step_reg   <= '0;
            phase_offset_reg <= '0;
            amplitude_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                mwg_pkg::REG_WAVE_MODE:    wave_mode_reg    <= cfg_wr_data[1:0];
                mwg_pkg::REG_PHASE_STEP:   phase_step_reg   <= cfg_wr_data[PB-1:0];
                mwg_pkg::REG_PHASE_OFFSET: phase_offset_reg <= cfg_wr_data[PB-1:0];
                mwg_pkg::REG_AMPLITUDE:    amplitude_reg    <= cfg_wr_data[AW-1:0];
            endcase
        end
    end

    // handshake
    logic s1_valid_reg;
    logic m_tvalid_reg;
    logic s2_ready;
    logic s_hs;

    assign s2_ready = !m_tvalid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s2_ready;
    assign s_hs     = s_tvalid && s_tready;

    // stage one: phase and unit wave
    logic [PB-1:0]       phase_acc_reg;
    logic [PB-1:0]       phase_acc_next;
    logic [PB-1:0]       x;
    logic [PB-1:0]       sine_sum;
    logic [TB-1:0]       sine_idx;
    logic [QB:0]         sine_k;
    logic [F:0]          sine_mag;
    logic [F+1:0]        tri_s;
    logic [F:0]          saw_s;
    logic signed [UW-1:0] unit;
    logic                unit_neg_next;
    logic [F:0]          unit_mag_next;
    logic                unit_neg_reg;
    logic [F:0]          unit_mag_reg;

    assign x              = s_tdata[0] ? '0 : phase_acc_reg;
    assign phase_acc_next = x + phase_step_reg;

    assign sine_sum = x + phase_offset_reg;
    assign sine_idx = sine_sum[PB-1 -: TB];
    // mirror the odd quadrants; k can reach a full quarter there
    assign sine_k   = sine_idx[TB-2] ? (QB+1)'(mwg_pkg::QUARTER) - {1'b0, sine_idx[QB-1:0]}
                                     : {1'b0, sine_idx[QB-1:0]};
    assign sine_mag = sine_k[QB] ? mwg_pkg::SINE_PEAK : mwg_pkg::SINE_LUT[sine_k[QB-1:0]];

    assign tri_s = x[PB-1 -: F+2];
    assign saw_s = x[PB-1 -: F+1];

    always_comb begin
        unique case (wave_mode_reg)
            mwg_pkg::MODE_SINE: begin
                unit = sine_idx[TB-1] ? -$signed({2'b00, sine_mag}) : $signed({2'b00, sine_mag});
            end
            mwg_pkg::MODE_SQUARE: begin
                unit = (x <= mwg_pkg::PHASE_HALF) ? mwg_pkg::UNIT_ONE : -mwg_pkg::UNIT_ONE;
            end
            mwg_pkg::MODE_TRIANGLE: begin
                unit = !x[PB-1] ? $signed({1'b0, tri_s}) - mwg_pkg::UNIT_ONE
                                : mwg_pkg::UNIT_THREE - $signed({1'b0, tri_s});
            end
            mwg_pkg::MODE_SAWTOOTH: begin
                unit = $signed({2'b00, saw_s}) - mwg_pkg::UNIT_ONE;
            end
        endcase
    end

    always_comb begin
        unit_neg_next = unit[UW-1];
        unit_mag_next = unit_neg_next ? (F+1)'(0) - unit[F:0] : unit[F:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            if (s_hs) begin
                phase_acc_reg <= phase_acc_next;
            end
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_hs) begin
            unit_neg_reg <= unit_neg_next;
            unit_mag_reg <= unit_mag_next;
        end
    end

    // stage two: scale by amplitude, round half away from zero
    logic [PW-1:0] scaled;
    logic [PW:0]   rounded;
    logic [SB-1:0] mag_out;
    logic [SB-1:0] sample_next;
    logic [SB-1:0] sample_reg;

    assign scaled      = amplitude_reg * unit_mag_reg;
    assign rounded     = {1'b0, scaled} + (PW+1)'(1 << (F - 1));
    assign mag_out     = rounded[F +: SB];
    assign sample_next = unit_neg_reg ? SB'(0) - mag_out : mag_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s2_ready) begin
            m_tvalid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            sample_reg <= sample_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = mwg_pkg::M_TDATA_W'(sample_reg);

    `MWG_ASSERT(a_restart_phase, s_hs && s_tdata[0] |=> phase_acc_reg == $past(phase_step_reg), "restart did not clear the phase")
    `MWG_ASSERT(a_phase_hold, !s_hs |=> $stable(phase_acc_reg), "phase moved without a transaction")
    `MWG_ASSERT(a_s1_hold, s1_valid_reg && !s2_ready |=> s1_valid_reg, "stage one dropped a stalled item")
    `MWG_ASSERT(a_out_source, $rose(m_tvalid_reg) |-> $past(s1_valid_reg), "sample appeared with no item in stage one")

endmodule

>>> dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RUN_LIMIT   = 200000;
    localparam int          RAND_TICKS  = 1400;
    localparam longint      WAVE_ONE    = 64'sd32768;      // 1.0 in Q1.15
    localparam longint      ROUND_HALF  = 64'sd16384;

    // quarter-wave sine polynomial, Q30
    localparam logic [63:0] SIN_C1  = 64'd1686629713;
    localparam logic [63:0] SIN_C3  = 64'd693598668;
    localparam logic [63:0] SIN_C5  = 64'd85569306;
    localparam logic [63:0] SIN_C7  = 64'd5026995;
    localparam logic [63:0] SIN_C9  = 64'd172272;
    localparam logic [63:0] SIN_C11 = 64'd3864;

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [mwg_pkg::S_TDATA_W-1:0]  s_tdata     = '0;     // [0] restart, [7:1] zero
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [mwg_pkg::M_TDATA_W-1:0]  m_tdata;              // [15:0] sample
    logic                           cfg_wr_en   = 1'b0;
    logic [mwg_pkg::CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [mwg_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

    multi_waveform_generator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // generator mirror: registers and phase
    logic [1:0]  mode_r   = mwg_pkg::MODE_SINE;
    logic [31:0] step_r   = '0;
    logic [31:0] offset_r = '0;
    logic [14:0] amp_r    = '0;
    logic [31:0] phase_r  = '0;

    bit          tick_q[$];
    logic [15:0] expected_samples[$];
    bit          src_fast  = 1'b0;
    bit          sink_fast = 1'b0;
    int unsigned src_gap   = 0;
    int unsigned sink_wait = 0;
    int unsigned fail_cnt  = 0;
    int unsigned checked_cnt = 0;
    int unsigned restart_cnt = 0;
    int unsigned cycle_cnt = 0;

    // unit wave in Q1.15 for phase x under the current mode
    function automatic longint wave_unit(logic [31:0] x);
        logic [31:0] ph;
        logic [9:0]  idx;
        logic [8:0]  k;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] r;
        logic [63:0] v;
        longint      s;
        case (mode_r)
            mwg_pkg::MODE_SINE: begin
                ph  = x + offset_r;
                idx = ph[31:22];
                k   = {1'b0, idx[7:0]};
                // mirror the odd quadrants around the quarter point
                if (idx[8]) begin
                    k = 9'd256 - k;
                end
                u  = 64'(k) << 22;
                u2 = (u * u) >> 30;
                r  = SIN_C11;
                r  = SIN_C9 - ((r * u2) >> 30);
                r  = SIN_C7 - ((r * u2) >> 30);
                r  = SIN_C5 - ((r * u2) >> 30);
                r  = SIN_C3 - ((r * u2) >> 30);
                r  = SIN_C1 - ((r * u2) >> 30);
                v  = (r * u) >> 30;
                v  = (v + 64'd16384) >> 15;
                if (v > 64'd32768) begin
                    v = 64'd32768;
                end
                return idx[9] ? -longint'(v) : longint'(v);
            end
            mwg_pkg::MODE_SQUARE: begin
                return (x <= 32'h8000_0000) ? WAVE_ONE : -WAVE_ONE;
            end
            mwg_pkg::MODE_TRIANGLE: begin
                s = longint'(x >> 15);
                return (s < 2 * WAVE_ONE) ? (s - WAVE_ONE) : (3 * WAVE_ONE - s);
            end
            default: begin
                return longint'(x >> 16) - WAVE_ONE;
            end
        endcase
    endfunction

    // sample for one tick; advances the phase
    function automatic logic [15:0] tick_sample(bit restart);
        longint unit;
        longint mag;
        if (restart) begin
            phase_r = '0;
        end
        unit    = wave_unit(phase_r);
        mag     = longint'(amp_r) * (unit < 0 ? -unit : unit);
        mag     = (mag + ROUND_HALF) >> 15;
        phase_r = phase_r + step_r;
        return (unit < 0) ? 16'(-mag) : 16'(mag);
    endfunction

    task automatic write_reg(logic [mwg_pkg::CFG_ADDR_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            mwg_pkg::REG_WAVE_MODE:    mode_r   = val[1:0];
            mwg_pkg::REG_PHASE_STEP:   step_r   = val;
            mwg_pkg::REG_PHASE_OFFSET: offset_r = val;
            mwg_pkg::REG_AMPLITUDE:    amp_r    = val[14:0];
            default: ;
        endcase
    endtask

    // hold until every queued tick is sent and every sample has come back
    task automatic wait_drained();
        @(negedge aclk);
        while (tick_q.size() != 0 || s_tvalid || expected_samples.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    // source: one tick per transaction, random gap after each
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_samples.push_back(tick_sample(s_tdata[0]));
                if (s_tdata[0]) begin
                    restart_cnt++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    s_tdata  <= mwg_pkg::S_TDATA_W'(tick_q.pop_front());
                    s_tvalid <= 1'b1;
                    src_gap  <= src_fast ? 0 : $urandom_range(0, 7);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink: check each sample transaction, then stall at random
    always @(posedge aclk) begin : sink
        int unsigned next_wait;
        logic [15:0] want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end else begin
            next_wait = sink_wait;
            if (m_tvalid && m_tready) begin
                checked_cnt++;
                if (expected_samples.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("unexpected sample %0d", $signed(m_tdata[15:0]));
                    end
                end else begin
                    want = expected_samples.pop_front();
                    if (m_tdata[15:0] !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("sample mismatch: expected %0d got %0d",
                                     $signed(want), $signed(m_tdata[15:0]));
                        end
                    end
                end
                next_wait = sink_fast ? 0 : $urandom_range(0, 7);
            end
            if (next_wait > 0) begin
                m_tready  <= 1'b0;
                sink_wait <= next_wait - 1;
            end else begin
                m_tready  <= 1'b1;
                sink_wait <= 0;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("multi_waveform_generator test failed");
            $finish;
        end
    end

    initial begin : stim
        logic [1:0]  all_modes[4];
        logic [31:0] val;
        int unsigned rand_ticks;
        int unsigned n;
        int unsigned phases;
        all_modes  = '{mwg_pkg::MODE_SINE, mwg_pkg::MODE_SQUARE,
                       mwg_pkg::MODE_TRIANGLE, mwg_pkg::MODE_SAWTOOTH};
        rand_ticks = 0;
        phases     = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset configuration: zero amplitude gives silence
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        wait_drained();

        // quarter-turn steps hit the peaks, zero crossings and the square half point
        write_reg(mwg_pkg::REG_AMPLITUDE, 32'hFFFF_FFFF);
        write_reg(mwg_pkg::REG_PHASE_STEP, 32'h4000_0000);
        write_reg(mwg_pkg::REG_PHASE_OFFSET, 32'h0);
        foreach (all_modes[i]) begin
            write_reg(mwg_pkg::REG_WAVE_MODE, {30'h3FFF_FFFF, all_modes[i]});
            tick_q.push_back(1'b1);
            repeat (4) tick_q.push_back(1'b0);
            wait_drained();
        end

        // full-scale step and offset, smallest amplitude
        write_reg(mwg_pkg::REG_WAVE_MODE, {30'h2AAA_AAAA, mwg_pkg::MODE_SINE});
        write_reg(mwg_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(mwg_pkg::REG_PHASE_OFFSET, 32'hFFFF_FFFF);
        write_reg(mwg_pkg::REG_AMPLITUDE, 32'h0000_0001);
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b0);
        wait_drained();

        while (rand_ticks < RAND_TICKS) begin
            src_fast  = ($urandom_range(0, 3) == 0);
            sink_fast = ($urandom_range(0, 3) == 0);

            val = $urandom();
            val[1:0] = all_modes[$urandom_range(0, 3)];
            write_reg(mwg_pkg::REG_WAVE_MODE, val);

            case ($urandom_range(0, 6))
                0: val = 32'h0;
                1: val = 32'h1;
                2: val = 32'hFFFF_FFFF;
                3: val = 32'h8000_0000;
                4: val = $urandom_range(0, 65535);
                default: val = $urandom();
            endcase
            write_reg(mwg_pkg::REG_PHASE_STEP, val);

            case ($urandom_range(0, 3))
                0: val = 32'h0;
                1: val = 32'hFFFF_FFFF;
                default: val = $urandom();
            endcase
            write_reg(mwg_pkg::REG_PHASE_OFFSET, val);

            val = $urandom();
            case ($urandom_range(0, 5))
                0: val[14:0] = 15'd0;
                1: val[14:0] = 15'd1;
                2: val[14:0] = 15'h7FFF;
                default: ;
            endcase
            write_reg(mwg_pkg::REG_AMPLITUDE, val);

            n = $urandom_range(10, 120);
            for (int i = 0; i < n; i++) begin
                tick_q.push_back($urandom_range(0, 15) == 0);
            end
            rand_ticks += n;
            phases++;
            wait_drained();
        end

        repeat (10) @(negedge aclk);
        $display("%0d random config phases plus directed mode sweeps, %0d ticks with %0d restarts",
                 phases, checked_cnt, restart_cnt);
        $display("all four waveforms at zero, unit and full amplitude, extreme steps and offsets");
        if (fail_cnt == 0 && expected_samples.size() == 0) begin
            $display("multi_waveform_generator test passed");
        end else begin
            $display("%0d failures, %0d samples outstanding", fail_cnt, expected_samples.size());
            $display("multi_waveform_generator test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/mwg_pkg.sv
rtl/multi_waveform_generator.sv
dv/tb.sv
